// ===== rtl/bat_pkg.sv =====
// shared types, codes and needle tables for the advertising tracker classifier
// no dependencies; imported by bat_examine, bat_walker and the top level
package bat_pkg;

  localparam int MAX_PACKET_BYTES_DEF = 255;

  typedef logic [7:0] byte_t;
  typedef logic [2:0] kind_t;

  localparam kind_t KIND_UNKNOWN  = 3'd0;
  localparam kind_t KIND_FM       = 3'd1;
  localparam kind_t KIND_FM_LOST  = 3'd2;
  localparam kind_t KIND_TL       = 3'd3;
  localparam kind_t KIND_ST       = 3'd4;
  localparam kind_t KIND_CP       = 3'd5;
  localparam kind_t KIND_FZ       = 3'd6;
  localparam kind_t KIND_SB       = 3'd7;

  // structure types
  localparam byte_t AD_MANUF      = 8'hFF;
  localparam byte_t AD_NAME_SHORT = 8'h08;
  localparam byte_t AD_NAME_FULL  = 8'h09;
  localparam byte_t AD_SVC_DATA16 = 8'h16;
  localparam byte_t AD_SOL_UUID16 = 8'h14;

  // company ids and manufacturer fields
  localparam logic [15:0] CID_FIRST  = 16'h004C;
  localparam logic [15:0] CID_SECOND = 16'h0075;
  localparam byte_t       MFR_OFFLINE_TYPE = 8'h12;
  localparam byte_t       STATUS_LOST_MASK = 8'h04;

  // 16-bit service uuids
  localparam logic [15:0] UUID_TL_A = 16'hFEED;
  localparam logic [15:0] UUID_TL_B = 16'hFEEC;
  localparam logic [15:0] UUID_ST   = 16'hFD5A;
  localparam logic [15:0] UUID_FM_A = 16'hFD44;
  localparam logic [15:0] UUID_FM_B = 16'hFD43;
  localparam logic [15:0] UUID_CP   = 16'hFE33;

  // name needles: entry 0 is the flipper prefix, the rest serial bridges
  localparam int N_PREFIX    = 11;
  localparam int PREFIX_MAXW = 9;
  localparam int PIDX_W      = $clog2(PREFIX_MAXW);

  typedef logic [N_PREFIX-1:0] flags_t;
  localparam flags_t FLAGS_ALL = '1;

  localparam byte_t PREFIX_TEXT [N_PREFIX][PREFIX_MAXW] = '{
    '{"F", "l", "i", "p", "p", "e", "r", 8'h00, 8'h00},
    '{"H", "C", "-", "0", "5", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"H", "C", "-", "0", "6", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"H", "C", "-", "0", "8", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"J", "D", "Y", "-", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"A", "T", "-", "0", "9", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"M", "L", "T", "-", "B", "T", "0", "5", 8'h00},
    '{"F", "C", "D", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"F", "R", "E", "E", "2", "M", "O", "V", "E"},
    '{"B", "T", "0", "5", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"H", "M", "-", "1", "0", 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam byte_t PREFIX_LEN [N_PREFIX] = '{
    8'd7, 8'd5, 8'd5, 8'd5, 8'd4, 8'd5, 8'd8, 8'd3, 8'd9, 8'd4, 8'd5
  };

  // completed structure as seen by the examiner
  typedef struct packed {
    byte_t           stype;
    byte_t           plen;
    logic [4:0][7:0] head;
    flags_t          flags;
  } view_t;

  typedef struct packed {
    logic  hit;
    kind_t kind;
  } decision_t;

endpackage

// ===== rtl/bat_examine.sv =====
// decision logic for one completed advertising structure
// depends on bat_pkg
module bat_examine (
  input  bat_pkg::view_t     view,
  output bat_pkg::decision_t dec
);
  import bat_pkg::*;

  logic [15:0] w;
  byte_t       status;
  logic        sb_hit;

  assign w      = {view.head[1], view.head[0]};
  assign status = (view.plen >= 8'd5) ? view.head[4] : view.head[3];

  always_comb begin
    sb_hit = 1'b0;
    for (int j = 1; j < N_PREFIX; j++) begin
      if (view.flags[j] && view.plen >= PREFIX_LEN[j]) sb_hit = 1'b1;
    end
  end

  always_comb begin
    dec.hit  = 1'b0;
    dec.kind = KIND_UNKNOWN;
    if (view.stype == AD_MANUF) begin
      if (view.plen >= 8'd3) begin
        if (w == CID_FIRST) begin
          dec.hit = 1'b1;
          if (view.plen >= 8'd4 && view.head[2] == MFR_OFFLINE_TYPE) begin
            dec.kind = ((status & STATUS_LOST_MASK) != 8'h00) ? KIND_FM_LOST : KIND_FM;
          end
        end else if (w == CID_SECOND && view.plen >= 8'd4) begin
          dec.hit  = 1'b1;
          dec.kind = KIND_ST;
        end
      end
    end else if (view.stype == AD_NAME_SHORT || view.stype == AD_NAME_FULL) begin
      if (view.plen >= 8'd3) begin
        if (view.flags[0] && view.plen >= PREFIX_LEN[0]) begin
          dec.hit  = 1'b1;
          dec.kind = KIND_FZ;
        end else if (sb_hit) begin
          dec.hit  = 1'b1;
          dec.kind = KIND_SB;
        end
      end
    end else if (view.stype == AD_SVC_DATA16 || view.stype == AD_SOL_UUID16) begin
      if (view.plen >= 8'd2) begin
        if (w == UUID_TL_A || w == UUID_TL_B) begin
          dec.hit  = 1'b1;
          dec.kind = KIND_TL;
        end else if (w == UUID_ST) begin
          dec.hit  = 1'b1;
          dec.kind = KIND_ST;
        end else if (w == UUID_FM_A || w == UUID_FM_B) begin
          dec.hit  = 1'b1;
          dec.kind = KIND_FM;
        end else if (w == UUID_CP) begin
          dec.hit  = 1'b1;
          dec.kind = KIND_CP;
        end
      end
    end
  end

endmodule

// ===== rtl/bat_walker.sv =====
// structure walker: length/type/payload tracking, head capture, needle flags
// depends on bat_pkg and bat_examine
module bat_walker #(
  parameter int MAX_PACKET_BYTES = bat_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  bat_pkg::byte_t data_byte,
  input  logic           last,
  output bat_pkg::kind_t result_kind
);
  import bat_pkg::*;

  localparam int PosW = $clog2(MAX_PACKET_BYTES + 1);

  logic [PosW-1:0] pos;
  byte_t           rem;
  byte_t           stype;
  byte_t           plen;
  byte_t           off;
  byte_t           head [5];
  flags_t          flags;
  logic            stopped;
  kind_t           kind;

  logic      walk_en;
  logic      is_type;
  logic      completes;
  flags_t    flags_next;
  view_t     view;
  decision_t dec;

  assign walk_en   = step && (pos < PosW'(MAX_PACKET_BYTES)) && !stopped;
  assign is_type   = ({1'b0, rem} == ({1'b0, plen} + 9'd1));
  // only a payload byte can complete a structure that decides
  assign completes = walk_en && (rem != 8'd0) && !is_type && (rem == 8'd1);

  always_comb begin
    for (int j = 0; j < N_PREFIX; j++) begin
      flags_next[j] = flags[j] &&
        !((off < PREFIX_LEN[j]) && (PREFIX_TEXT[j][off[PIDX_W-1:0]] != data_byte));
    end
  end

  always_comb begin
    view.stype = stype;
    view.plen  = plen;
    view.flags = flags_next;
    for (int i = 0; i < 5; i++) begin
      view.head[i] = (off == 8'(i)) ? data_byte : head[i];
    end
  end

  bat_examine u_examine (
    .view (view),
    .dec  (dec)
  );

  assign result_kind = (completes && dec.hit) ? dec.kind : kind;

  always_ff @(posedge clk) begin
    if (walk_en && rem != 8'd0 && !is_type && off < 8'd5) begin
      head[off[2:0]] <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last)) begin
      pos     <= '0;
      rem     <= 8'd0;
      stype   <= 8'd0;
      plen    <= 8'd0;
      off     <= 8'd0;
      flags   <= FLAGS_ALL;
      stopped <= 1'b0;
      kind    <= KIND_UNKNOWN;
    end else if (step) begin
      if (pos < PosW'(MAX_PACKET_BYTES)) pos <= pos + PosW'(1);
      if (walk_en) begin
        if (rem == 8'd0) begin
          if (data_byte == 8'd0) begin
            stopped <= 1'b1;
          end else begin
            rem   <= data_byte;
            plen  <= data_byte - 8'd1;
            off   <= 8'd0;
            flags <= FLAGS_ALL;
          end
        end else begin
          rem <= rem - 8'd1;
          if (is_type) begin
            stype <= data_byte;
          end else begin
            flags <= flags_next;
            if (off != 8'hFF) off <= off + 8'd1;
          end
          if (completes && dec.hit) begin
            kind    <= dec.kind;
            stopped <= 1'b1;
          end
        end
      end
    end
  end

endmodule

// ===== rtl/ble_adv_tracker_classifier_top.sv =====
// top level of the advertising tracker classifier: input register, walker, result register
// depends on bat_pkg and bat_walker
//
// usage
//   input channel: item_valid/item_ready carry one payload word per handshake,
//   data_byte plus last, where last marks the final byte of a packet
//   result channel: result_valid/result_ready carry one kind word per packet,
//   emitted only for the byte flagged last
//   each word is taken into an input register and walked through the structure
//   parser in the following cycle, unless it is a last byte held back by a
//   waiting result; a packet's kind lands in the result register at the edge
//   where its last byte leaves the input register
//   throughput: one byte per cycle, limited by the single walker step and by a
//   last byte held for a waiting result; results may follow back to back
//   stall: while a result waits, non-last bytes keep flowing; a last byte is
//   held in the input register until the result register frees
//   reset: rst (synchronous) empties both registers and clears packet state;
//   item_ready is high from the first cycle after reset
module ble_adv_tracker_classifier_top #(
  parameter int MAX_PACKET_BYTES = bat_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  bat_pkg::byte_t data_byte,
  input  logic           last,
  output logic           result_valid,
  input  logic           result_ready,
  output bat_pkg::kind_t kind
);
  import bat_pkg::*;

  // input register
  logic  in_full;
  byte_t in_byte;
  logic  in_last;

  logic  advance;
  kind_t walk_kind;

  // a last byte may only move on when the result register can take its kind
  assign advance    = in_full && (!in_last || !result_valid || result_ready);
  assign item_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (item_ready) begin
      in_full <= item_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      in_byte <= data_byte;
      in_last <= last;
    end
  end

  bat_walker #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_walker (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .data_byte   (in_byte),
    .last        (in_last),
    .result_kind (walk_kind)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && in_last) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) kind <= walk_kind;
  end

  // non-last bytes are never held back
  a_body_flows: assert property (@(posedge clk) disable iff (rst)
    in_full && !in_last |-> item_ready)
    else $error("input stalled on a non-last byte");

  // a result only appears after a last byte has been walked
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(advance && in_last))
    else $error("result raised without a last byte");

  // a pending last byte waits while the result is refused
  a_last_held: assert property (@(posedge clk) disable iff (rst)
    in_full && in_last && result_valid && !result_ready |-> !item_ready && !advance)
    else $error("last byte overran a waiting result");

endmodule
